@@ sv/pde_pkg.sv @@
// Shared constants and types for the proper divisor enumerator.
`timescale 1ns / 1ps

package pde_pkg;

  // Default width of the examined value.
  localparam int unsigned ValueWidthDef = 12;

  // Widths of the result fields.
  localparam int unsigned DivisorW = 11;
  localparam int unsigned OrdinalW = 6;

  // Largest number of divisors listed for one value.
  localparam int unsigned MaxResults = 46;

  // First trial candidate.
  localparam int unsigned FirstCand = 2;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StDiv,
    StTest,
    StFinish
  } state_e;

endpackage

@@ sv/proper_divisor_enumerator_top.sv @@
// Top level of the proper divisor enumerator, with its bit-serial trial divider.
`timescale 1ns / 1ps

// The block takes one unsigned word, value_i, and lists every divisor d with
// 2 <= d <= value/2 in ascending order, one result word per divisor. Each
// result carries the divisor, its ordinal counted from one and a last marker,
// so the ordinal of the last word is the divisor count. A value with no such
// divisor (a prime, or anything below four) gives a single word with
// has_divisor_o low, divisor and ordinal zero and is_last_o high. Should a
// value have more than MaxResults divisors, the list stops at that many and
// the last word listed carries the marker. Every candidate is tested by a
// restoring divider that takes one bit of the value per cycle: a set-up
// step, VALUE_WIDTH shift and subtract steps and a step that looks at the
// remainder. The search waits when it has a word to give and out_stall_i
// holds the output. The block works on one value at a time and takes the
// next word once the last result of the previous one sits in the output
// register; that register keeps a finished word while the next value is
// accepted. Both channels use valid and stall: a word moves at a rising edge
// with valid high and stall low.
module proper_divisor_enumerator_top #(
  parameter int unsigned VALUE_WIDTH = pde_pkg::ValueWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [VALUE_WIDTH-1:0]        value_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pde_pkg::DivisorW-1:0]  divisor_o,
  output logic [pde_pkg::OrdinalW-1:0]  ordinal_o,
  output logic                          is_last_o,
  output logic                          has_divisor_o
);

  localparam int unsigned BitCntW = $clog2(VALUE_WIDTH);
  localparam int unsigned ExtW    = pde_pkg::DivisorW + VALUE_WIDTH;

  // Control state.
  pde_pkg::state_e              state_q, state_d;
  logic [BitCntW-1:0]           bit_cnt_q, bit_cnt_d;
  logic [pde_pkg::OrdinalW-1:0] count_q, count_d;
  logic                         pend_vld_q, pend_vld_d;
  logic                         out_valid_q, out_valid_d;

  // Datapath.
  logic [VALUE_WIDTH-1:0]       val_q, val_d;
  logic [VALUE_WIDTH-1:0]       cand_q, cand_d;
  logic [VALUE_WIDTH-1:0]       rem_q, rem_d;
  logic [VALUE_WIDTH-1:0]       shift_q, shift_d;
  logic [VALUE_WIDTH-1:0]       pend_div_q, pend_div_d;

  // Output register.
  logic [pde_pkg::DivisorW-1:0] div_out_q, div_out_d;
  logic [pde_pkg::OrdinalW-1:0] ord_out_q, ord_out_d;
  logic                         last_out_q, last_out_d;
  logic                         has_out_q, has_out_d;

  logic [VALUE_WIDTH:0]         trial;
  logic [ExtW-1:0]              pend_ext;
  logic                         out_free;

  // One restoring step: bring in the next bit of the value, take off the
  // candidate if it fits.
  assign trial    = {rem_q, shift_q[VALUE_WIDTH-1]};
  assign pend_ext = ExtW'(pend_div_q);
  // The output register can take a new word this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pde_pkg::StIdle;
      bit_cnt_q   <= '0;
      count_q     <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      count_q     <= count_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    cand_q     <= cand_d;
    rem_q      <= rem_d;
    shift_q    <= shift_d;
    pend_div_q <= pend_div_d;
    div_out_q  <= div_out_d;
    ord_out_q  <= ord_out_d;
    last_out_q <= last_out_d;
    has_out_q  <= has_out_d;
  end

  // A divisor found is held back until the next one turns up or the search
  // ends, because only then is it known whether it is the last.
  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    count_d     = count_q;
    pend_vld_d  = pend_vld_q;
    val_d       = val_q;
    cand_d      = cand_q;
    rem_d       = rem_q;
    shift_d     = shift_q;
    pend_div_d  = pend_div_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_out_d   = div_out_q;
    ord_out_d   = ord_out_q;
    last_out_d  = last_out_q;
    has_out_d   = has_out_q;
    in_stall_o  = 1'b1;

    unique case (state_q)
      pde_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          val_d      = value_i;
          cand_d     = VALUE_WIDTH'(pde_pkg::FirstCand);
          count_d    = '0;
          pend_vld_d = 1'b0;
          state_d    = pde_pkg::StStart;
        end
      end

      pde_pkg::StStart: begin
        if (cand_q > (val_q >> 1)) begin
          state_d = pde_pkg::StFinish;
        end else begin
          rem_d     = '0;
          shift_d   = val_q;
          bit_cnt_d = '0;
          state_d   = pde_pkg::StDiv;
        end
      end

      pde_pkg::StDiv: begin
        if (trial >= {1'b0, cand_q}) begin
          rem_d = VALUE_WIDTH'(trial - {1'b0, cand_q});
        end else begin
          rem_d = trial[VALUE_WIDTH-1:0];
        end
        shift_d   = shift_q << 1;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BitCntW'(VALUE_WIDTH - 1)) begin
          state_d = pde_pkg::StTest;
        end
      end

      pde_pkg::StTest: begin
        if (rem_q != '0) begin
          cand_d  = cand_q + 1'b1;
          state_d = pde_pkg::StStart;
        end else if (!pend_vld_q || out_free) begin
          // Release the held divisor, which is now known not to be the last.
          if (pend_vld_q) begin
            out_valid_d = 1'b1;
            div_out_d   = pend_ext[pde_pkg::DivisorW-1:0];
            ord_out_d   = count_q;
            last_out_d  = 1'b0;
            has_out_d   = 1'b1;
          end
          pend_div_d = cand_q;
          pend_vld_d = 1'b1;
          count_d    = count_q + 1'b1;
          cand_d     = cand_q + 1'b1;
          if (count_d == pde_pkg::OrdinalW'(pde_pkg::MaxResults)) begin
            state_d = pde_pkg::StFinish;
          end else begin
            state_d = pde_pkg::StStart;
          end
        end
      end

      pde_pkg::StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_out_d  = 1'b1;
          if (pend_vld_q) begin
            div_out_d = pend_ext[pde_pkg::DivisorW-1:0];
            ord_out_d = count_q;
            has_out_d = 1'b1;
          end else begin
            div_out_d = '0;
            ord_out_d = '0;
            has_out_d = 1'b0;
          end
          pend_vld_d = 1'b0;
          state_d    = pde_pkg::StIdle;
        end
      end

      default: begin
        state_d = pde_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign divisor_o     = div_out_q;
  assign ordinal_o     = ord_out_q;
  assign is_last_o     = last_out_q;
  assign has_divisor_o = has_out_q;

`ifndef SYNTHESIS
  // The partial remainder stays below the candidate throughout the division.
  a_rem_below_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pde_pkg::StDiv |-> rem_q < cand_q)
    else $error("partial remainder reached the candidate");

  // A word without a divisor is always the only, and so the last, word.
  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_divisor_o |-> is_last_o && ordinal_o == '0 && divisor_o == '0)
    else $error("word without divisor is malformed");

  // A listed divisor has an ordinal from one up to the list limit.
  a_ordinal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_divisor_o |->
      ordinal_o != '0 && ordinal_o <= pde_pkg::OrdinalW'(pde_pkg::MaxResults))
    else $error("ordinal out of range");
`endif

endmodule
